// ===== src/ttcb_pkg.sv =====
// ----------------------------------------------------------------------------
// ttcb_pkg: shared types and constants of the countdown timer bank.
// Holds the channel counts, operation codes, channel modes, controller
// states and the command structure between controller and datapath.
// ----------------------------------------------------------------------------
package ttcb_pkg;

    localparam int SEC_CHANNELS  = 8;
    localparam int TICK_CHANNELS = 8;
    localparam int ALL_CHANNELS  = SEC_CHANNELS + TICK_CHANNELS;
    localparam int IDX_W         = $clog2(ALL_CHANNELS);

    typedef enum logic [3:0] {
        OP_TICK       = 4'd0,
        OP_ARM_IDLE   = 4'd1,
        OP_ARM_FORCE  = 4'd2,
        OP_PAUSE      = 4'd3,
        OP_RESUME     = 4'd4,
        OP_RESET      = 4'd5,
        OP_POLL_DONE  = 4'd6,
        OP_ONESHOT    = 4'd7,
        OP_RELOAD     = 4'd8,
        OP_SET_PERIOD = 4'd9,
        OP_POLL_PER   = 4'd10,
        OP_PER_EVENT  = 4'd11,
        OP_READ       = 4'd12,
        OP_SET_SEC    = 4'd13,
        OP_SET_SUB    = 4'd14,
        OP_NONE       = 4'd15
    } t_op;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_RUN   = 2'd1,
        MODE_PAUSE = 2'd2,
        MODE_DONE  = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMD,
        ST_SWEEP,
        ST_REPORT,
        ST_OUT
    } t_state;

    // Controller to datapath commands.
    typedef struct packed {
        logic             load;     // capture the input word
        logic             exec;     // run the captured command or time-base step
        logic             sweep;    // update channel at sweep index
        logic [IDX_W-1:0] sweep_idx;
        logic             report;   // build the result word
    } t_cmd;

endpackage

// ===== src/ttcb_datapath.sv =====
// ----------------------------------------------------------------------------
// ttcb_datapath: time base, channel stores and result register.
// Executes one command per exec pulse, one channel of the tick
// sweep per sweep pulse, and assembles the result word on report.
// ----------------------------------------------------------------------------
module ttcb_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    input  logic [15:0]         i_cfg_data,
    input  ttcb_pkg::t_cmd      i_cmd,
    input  logic [3:0]          i_op,
    input  logic                i_bank,
    input  logic [2:0]          i_channel,
    input  logic [31:0]         i_value,
    output logic                o_is_tick,
    output logic                o_event_res,
    output logic [1:0]          o_chan_status,
    output logic [31:0]         o_elapsed,
    output logic [31:0]         o_left,
    output logic                o_window_flag,
    output logic [31:0]         o_now_seconds,
    output logic [15:0]         o_now_ticks
);

    localparam int IW = ttcb_pkg::IDX_W;
    localparam int N  = ttcb_pkg::ALL_CHANNELS;

    logic [15:0]          r_tps;
    logic [31:0]          r_sec, n_sec;
    logic [15:0]          r_sub, n_sub;
    logic                 r_rolled;
    ttcb_pkg::t_op        r_op;
    logic [31:0]          r_val;
    logic [IW-1:0]        r_idx;
    logic                 r_idx_ok;
    logic                 r_res;

    ttcb_pkg::t_mode      r_mode [N];
    logic [31:0]          r_goal [N];
    logic [31:0]          r_left [N];
    logic [31:0]          r_rel  [N];
    logic [31:0]          r_wend [N];
    logic                 r_wflag[N];

    logic                 idx_ok;
    logic [IW-1:0]        idx;
    logic [16:0]          sub_inc;
    logic [15:0]          tps_eff;
    logic                 rolls;

    // Addressed channel fields.
    ttcb_pkg::t_mode      a_mode;
    logic [31:0]          a_goal, a_left, a_rel, a_wend, a_done;
    logic                 a_wflag, a_due;
    logic [32:0]          a_end;

    // Sweep channel.
    ttcb_pkg::t_mode      s_mode;
    logic [31:0]          s_left;
    logic                 s_dec;

    always_comb begin
        idx_ok = i_bank ? ({1'b0, i_channel} < 4'(ttcb_pkg::TICK_CHANNELS))
                        : ({1'b0, i_channel} < 4'(ttcb_pkg::SEC_CHANNELS));
        idx    = i_bank ? IW'(ttcb_pkg::SEC_CHANNELS) + IW'(i_channel) : IW'(i_channel);
    end

    assign o_is_tick = (r_op == ttcb_pkg::OP_TICK);

    always_comb begin
        a_mode  = r_mode[r_idx];
        a_goal  = r_goal[r_idx];
        a_left  = r_left[r_idx];
        a_rel   = r_rel[r_idx];
        a_wend  = r_wend[r_idx];
        a_wflag = r_wflag[r_idx];
        a_done  = a_goal - a_left;
        a_due   = a_wflag && ((a_done >= a_goal) || (a_wend <= a_done));
        a_end   = {1'b0, a_done} + {1'b0, r_val};
        if (a_end > {1'b0, a_goal}) begin
            a_end = {1'b0, a_goal};
        end
    end

    always_comb begin
        tps_eff = (r_tps == 16'd0) ? 16'd1 : r_tps;
        sub_inc = {1'b0, r_sub} + 17'd1;
        rolls   = (sub_inc >= {1'b0, tps_eff});
        n_sub   = rolls ? 16'd0 : sub_inc[15:0];
        n_sec   = rolls ? r_sec + 32'd1 : r_sec;
    end

    always_comb begin
        s_mode = r_mode[i_cmd.sweep_idx];
        s_left = r_left[i_cmd.sweep_idx];
        s_dec  = (i_cmd.sweep_idx >= IW'(ttcb_pkg::SEC_CHANNELS)) || r_rolled;
        if (s_dec && s_left != 32'd0) begin
            s_left = s_left - 32'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps    <= 16'd1;
            r_sec    <= 32'd0;
            r_sub    <= 16'd0;
            r_rolled <= 1'b0;
            r_op     <= ttcb_pkg::OP_NONE;
            r_res    <= 1'b0;
            r_idx_ok <= 1'b0;
            for (int i = 0; i < N; i++) begin
                r_mode[i]  <= ttcb_pkg::MODE_IDLE;
                r_goal[i]  <= 32'd0;
                r_left[i]  <= 32'd0;
                r_rel[i]   <= 32'd0;
                r_wend[i]  <= 32'd0;
                r_wflag[i] <= 1'b0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_tps <= i_cfg_data;
            end
            if (i_cmd.load) begin
                r_op     <= ttcb_pkg::t_op'(i_op);
                r_val    <= i_value;
                r_idx    <= idx;
                r_idx_ok <= idx_ok;
                r_res    <= 1'b0;
            end
            if (i_cmd.exec) begin
                unique case (r_op)
                    ttcb_pkg::OP_TICK: begin
                        r_sub    <= n_sub;
                        r_sec    <= n_sec;
                        r_rolled <= rolls;
                    end
                    ttcb_pkg::OP_SET_SEC: r_sec <= r_val;
                    ttcb_pkg::OP_SET_SUB: r_sub <= r_val[15:0];
                    default: begin
                        if (r_idx_ok) begin
                            unique case (r_op)
                                ttcb_pkg::OP_ARM_IDLE: begin
                                    if (a_mode == ttcb_pkg::MODE_IDLE) begin
                                        r_goal[r_idx] <= r_val;
                                        r_left[r_idx] <= r_val;
                                        r_rel[r_idx]  <= r_val;
                                        r_mode[r_idx] <= ttcb_pkg::MODE_RUN;
                                    end
                                end
                                ttcb_pkg::OP_ARM_FORCE: begin
                                    r_goal[r_idx]  <= r_val;
                                    r_left[r_idx]  <= r_val;
                                    r_rel[r_idx]   <= r_val;
                                    r_mode[r_idx]  <= ttcb_pkg::MODE_RUN;
                                    r_wend[r_idx]  <= 32'd0;
                                    r_wflag[r_idx] <= 1'b0;
                                end
                                ttcb_pkg::OP_PAUSE:  r_mode[r_idx] <= ttcb_pkg::MODE_PAUSE;
                                ttcb_pkg::OP_RESUME: r_mode[r_idx] <= ttcb_pkg::MODE_RUN;
                                ttcb_pkg::OP_RESET: begin
                                    r_mode[r_idx]  <= ttcb_pkg::MODE_IDLE;
                                    r_goal[r_idx]  <= 32'd0;
                                    r_left[r_idx]  <= 32'd0;
                                    r_rel[r_idx]   <= 32'd0;
                                    r_wend[r_idx]  <= 32'd0;
                                    r_wflag[r_idx] <= 1'b0;
                                end
                                ttcb_pkg::OP_POLL_DONE:
                                    r_res <= (a_mode == ttcb_pkg::MODE_DONE);
                                ttcb_pkg::OP_ONESHOT: begin
                                    if (a_mode == ttcb_pkg::MODE_DONE) begin
                                        r_mode[r_idx]  <= ttcb_pkg::MODE_IDLE;
                                        r_goal[r_idx]  <= 32'd0;
                                        r_left[r_idx]  <= 32'd0;
                                        r_rel[r_idx]   <= 32'd0;
                                        r_wend[r_idx]  <= 32'd0;
                                        r_wflag[r_idx] <= 1'b0;
                                        r_res          <= 1'b1;
                                    end
                                end
                                ttcb_pkg::OP_RELOAD: begin
                                    if (a_mode == ttcb_pkg::MODE_DONE) begin
                                        r_mode[r_idx]  <= ttcb_pkg::MODE_RUN;
                                        r_goal[r_idx]  <= a_rel;
                                        r_left[r_idx]  <= a_rel;
                                        r_wend[r_idx]  <= 32'd0;
                                        r_wflag[r_idx] <= 1'b0;
                                        r_res          <= 1'b1;
                                    end
                                end
                                ttcb_pkg::OP_SET_PERIOD: begin
                                    if (!a_wflag && a_done < a_goal) begin
                                        r_wend[r_idx]  <= a_end[31:0];
                                        r_wflag[r_idx] <= 1'b1;
                                    end
                                end
                                ttcb_pkg::OP_POLL_PER: r_res <= a_due;
                                ttcb_pkg::OP_PER_EVENT: begin
                                    if (a_due) begin
                                        r_wflag[r_idx] <= 1'b0;
                                        r_res          <= 1'b1;
                                    end
                                end
                                default: ;
                            endcase
                        end
                    end
                endcase
            end
            if (i_cmd.sweep && s_mode == ttcb_pkg::MODE_RUN) begin
                r_left[i_cmd.sweep_idx] <= s_left;
                if (s_left == 32'd0) begin
                    r_mode[i_cmd.sweep_idx] <= ttcb_pkg::MODE_DONE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.report) begin
            o_event_res   <= r_idx_ok & r_res;
            o_chan_status <= r_idx_ok ? a_mode : 2'd0;
            o_elapsed     <= r_idx_ok ? a_done : 32'd0;
            o_left        <= r_idx_ok ? a_left : 32'd0;
            o_window_flag <= r_idx_ok & a_wflag;
            o_now_seconds <= r_sec;
            o_now_ticks   <= r_sub;
        end
    end

endmodule

// ===== src/ttcb_ctrl.sv =====
// ----------------------------------------------------------------------------
// ttcb_ctrl: sequencer of the countdown timer bank.
// Takes a word, runs it, sweeps all channels after a tick, then holds
// the result until the consumer takes it.
// ----------------------------------------------------------------------------
module ttcb_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  logic           i_is_tick,
    output ttcb_pkg::t_cmd o_cmd
);

    localparam int IW = ttcb_pkg::IDX_W;

    ttcb_pkg::t_state r_state, n_state;
    logic [IW-1:0]    r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ttcb_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        o_cmd         = '0;
        o_cmd.sweep_idx = r_cnt;
        o_in_ready    = 1'b0;
        o_out_valid   = 1'b0;
        unique case (r_state)
            ttcb_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ttcb_pkg::ST_CMD;
                end
            end
            ttcb_pkg::ST_CMD: begin
                o_cmd.exec = 1'b1;
                n_cnt      = '0;
                n_state    = i_is_tick ? ttcb_pkg::ST_SWEEP : ttcb_pkg::ST_REPORT;
            end
            ttcb_pkg::ST_SWEEP: begin
                o_cmd.sweep = 1'b1;
                n_cnt       = r_cnt + 1'b1;
                if (r_cnt == IW'(ttcb_pkg::ALL_CHANNELS - 1)) begin
                    n_state = ttcb_pkg::ST_REPORT;
                end
            end
            ttcb_pkg::ST_REPORT: begin
                o_cmd.report = 1'b1;
                n_state      = ttcb_pkg::ST_OUT;
            end
            ttcb_pkg::ST_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = ttcb_pkg::ST_IDLE;
                end
            end
            default: n_state = ttcb_pkg::ST_IDLE;
        endcase
    end

endmodule

// ===== src/tick_timebase_countdown_bank_top.sv =====
// ----------------------------------------------------------------------------
// tick_timebase_countdown_bank_top: time base with two countdown banks.
// ----------------------------------------------------------------------------
// One word is handled at a time. An accepted word is run in the command
// state, the result word is built in the report state and is then held in
// the output state. For a tick, the time-base step runs in the command state,
// and the controller then walks all sixteen channels one per cycle through
// the shared read-modify-write path before the report state. The next word
// is accepted in the cycle after the result is taken. The configuration port
// is always ready and must only be written while the block is idle.
module tick_timebase_countdown_bank_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_ticks_per_second,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [3:0]  i_op,
    input  logic        i_bank,
    input  logic [2:0]  i_channel,
    input  logic [31:0] i_value,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_event_res,
    output logic [1:0]  o_chan_status,
    output logic [31:0] o_elapsed,
    output logic [31:0] o_left,
    output logic        o_window_flag,
    output logic [31:0] o_now_seconds,
    output logic [15:0] o_now_ticks
);

    ttcb_pkg::t_cmd cmd;
    logic           is_tick;

    assign o_cfg_ready = 1'b1;

    ttcb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_is_tick   (is_tick),
        .o_cmd       (cmd)
    );

    ttcb_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_ticks_per_second),
        .i_cmd         (cmd),
        .i_op          (i_op),
        .i_bank        (i_bank),
        .i_channel     (i_channel),
        .i_value       (i_value),
        .o_is_tick     (is_tick),
        .o_event_res   (o_event_res),
        .o_chan_status (o_chan_status),
        .o_elapsed     (o_elapsed),
        .o_left        (o_left),
        .o_window_flag (o_window_flag),
        .o_now_seconds (o_now_seconds),
        .o_now_ticks   (o_now_ticks)
    );

endmodule

// ===== src/ttcb_checker.sv =====
// ----------------------------------------------------------------------------
// ttcb_checker: port-level checks of the countdown timer bank.
// Watches the handshakes and result word of the top level.
// ----------------------------------------------------------------------------
module ttcb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        i_in_valid,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_chan_status,
    input logic [31:0] o_left
);

    // Only one word is in flight: no input is taken while a result waits.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid)) else $error("ready while result pending");

    // No result is valid while an accepted word is in the command state or the state after it.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_out_valid ##1 !o_out_valid)
        else $error("result too early");

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid && $stable(o_left))
        else $error("result changed while stalled");

    // An idle channel always reports nothing left.
    a_idle_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_chan_status == 2'd0) |-> (o_left == 32'd0))
        else $error("idle channel with remaining count");

endmodule

bind tick_timebase_countdown_bank_top ttcb_checker u_ttcb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_ready    (o_in_ready),
    .i_in_valid    (i_in_valid),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_chan_status (o_chan_status),
    .o_left        (o_left)
);
